// ===== hw/rtl/vdft_pkg.sv =====
// ----------------------------------------------------------------------------
// vdft_pkg
// Types, constants and the key hash shared by the vertex welding blocks.
// ----------------------------------------------------------------------------
package vdft_pkg;

  localparam int unsigned IdxW           = 14;
  localparam int unsigned VtxW           = 15;
  localparam int unsigned KeyW           = 44;
  localparam int unsigned VertexCapacity = 32768;
  localparam int unsigned VtxCntW        = 16;
  localparam int unsigned IndexCapacity  = 65536;
  localparam int unsigned EmitW          = 17;
  localparam int unsigned FaceCorners    = 16;
  localparam int unsigned FaceCntW       = 5;
  localparam int unsigned HashW          = 16;
  localparam int unsigned HashDepth      = 65536;

  typedef struct packed {
    logic            face_start;
    logic [IdxW-1:0] position_index;
    logic            uv_present;
    logic [IdxW-1:0] uv_index;
    logic            normal_present;
    logic [IdxW-1:0] normal_index;
  } in_t;

  typedef struct packed {
    logic [VtxW-1:0] vertex_index;
    logic            vertex_is_new;
    logic            table_overflow;
    logic            corner_dropped;
    logic            triangle_valid;
    logic [VtxW-1:0] tri_first;
    logic [VtxW-1:0] tri_second;
    logic [VtxW-1:0] tri_third;
  } out_t;

  typedef struct packed {
    logic             face_start;
    logic [KeyW-1:0]  key;
    logic [HashW-1:0] hash;
  } corner_t;

  typedef struct packed {
    logic [VtxW:0] tag;
  } slot_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HCHK,
    ST_KCHK,
    ST_FIN
  } state_e;

  typedef enum logic [1:0] {
    RES_NORMAL,
    RES_FACE_DROP,
    RES_OVERFLOW
  } res_e;

  function automatic logic [HashW-1:0] key_hash(input logic [KeyW-1:0] k);
    key_hash = k[15:0] ^ k[31:16] ^ {k[43:32], k[43:40]} ^ {k[7:0], k[15:8]};
  endfunction

endpackage

// ===== hw/rtl/vertex_dedup_fan_triangulator.sv =====
// ----------------------------------------------------------------------------
// vertex_dedup_fan_triangulator
// Welds face corners into distinct vertices and emits fan triangles.
//
//   channel | signals                          | word
//   in      | in_valid_i / in_ready_o          | in_data_i  (one corner)
//   out     | out_valid_o / out_ready_i        | out_data_o (one result)
//
// A corner reads its first hash slot; on an occupied slot the stored key is
// compared, and a mismatch probes the next slot linearly. A corner dropped
// at the face limit skips the probe. The hash and key store reads are registered.
// After reset all 65536 hash store slots are cleared; meanwhile only
// the queue takes corners, two at most.
// A two-entry queue lets input run ahead while a result waits at the output.
// ----------------------------------------------------------------------------
module vertex_dedup_fan_triangulator (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  vdft_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output vdft_pkg::out_t out_data_o
);
  import vdft_pkg::*;

  logic    q_valid;
  logic    q_pop;
  corner_t q_data;

  vdft_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (q_valid),
    .q_data_o   (q_data),
    .q_pop_i    (q_pop)
  );

  vdft_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== hw/rtl/vdft_front.sv =====
// ----------------------------------------------------------------------------
// vdft_front
// Accepts corners, forms the welding key and its hash, queues two deep.
// ----------------------------------------------------------------------------
module vdft_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  vdft_pkg::in_t    in_data_i,
  output logic             q_valid_o,
  output vdft_pkg::corner_t q_data_o,
  input  logic             q_pop_i
);
  import vdft_pkg::*;

  corner_t     buf_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        push;
  logic        pop;
  logic [KeyW-1:0] key;
  corner_t     ent;

  always_comb begin
    key = {in_data_i.position_index,
           in_data_i.uv_present,
           in_data_i.uv_present ? in_data_i.uv_index : IdxW'(0),
           in_data_i.normal_present,
           in_data_i.normal_present ? in_data_i.normal_index : IdxW'(0)};
    ent.face_start = in_data_i.face_start;
    ent.key        = key;
    ent.hash       = key_hash(key);
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_data_o   = buf_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_ptr_q] <= ent;
  end

endmodule

// ===== hw/rtl/vdft_back.sv =====
// ----------------------------------------------------------------------------
// vdft_back
// Hash probe against the key store, vertex append and fan triangle output.
// ----------------------------------------------------------------------------
module vdft_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  vdft_pkg::corner_t q_data_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output vdft_pkg::out_t    out_data_o
);
  import vdft_pkg::*;

  logic [VtxW:0]     hash_mem [HashDepth];
  logic [KeyW-1:0]   key_mem  [VertexCapacity];

  state_e            state_q, state_d;
  logic [HashW-1:0]  clr_q, clr_d;
  logic [HashW-1:0]  slot_q, slot_d;
  corner_t           cur_q, cur_d;
  res_e              res_q, res_d;
  logic [VtxW-1:0]   vtx_q, vtx_d;
  logic              new_q, new_d;
  logic [VtxCntW-1:0] vcnt_q, vcnt_d;
  logic [EmitW-1:0]  emit_q, emit_d;
  logic [VtxW-1:0]   first_q, first_d;
  logic [VtxW-1:0]   prev_q, prev_d;
  logic [FaceCntW-1:0] fcc_q, fcc_d;
  logic              out_valid_q, out_valid_d;
  out_t              out_q, out_d;

  logic              h_we, h_re, k_we, k_re;
  logic [HashW-1:0]  h_waddr, h_raddr;
  logic [VtxW:0]     h_wdata, h_rd_q;
  logic [VtxW-1:0]   k_raddr;
  logic [KeyW-1:0]   k_rd_q;
  logic [FaceCntW-1:0] fcc_eff;
  logic              out_free;
  logic              tri_ok;
  logic [EmitW:0]    emit_sum;

  assign out_free = !out_valid_q || out_ready_i;
  assign fcc_eff  = q_data_i.face_start ? '0 : fcc_q;
  assign emit_sum = {1'b0, emit_q} + (EmitW+1)'(3);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == HashW'(HashDepth - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (q_valid_i) begin
          state_d = (fcc_eff >= FaceCntW'(FaceCorners)) ? ST_FIN : ST_HCHK;
        end
      end
      ST_HCHK: state_d = h_rd_q[VtxW] ? ST_KCHK : ST_FIN;
      ST_KCHK: state_d = (k_rd_q == cur_q.key) ? ST_FIN : ST_HCHK;
      ST_FIN:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    clr_d       = clr_q;
    slot_d      = slot_q;
    cur_d       = cur_q;
    res_d       = res_q;
    vtx_d       = vtx_q;
    new_d       = new_q;
    vcnt_d      = vcnt_q;
    emit_d      = emit_q;
    first_d     = first_q;
    prev_d      = prev_q;
    fcc_d       = fcc_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    q_pop_o     = 1'b0;
    h_we        = 1'b0;
    h_waddr     = slot_q;
    h_wdata     = {1'b1, vcnt_q[VtxW-1:0]};
    h_re        = 1'b0;
    h_raddr     = slot_q;
    k_we        = 1'b0;
    k_re        = 1'b0;
    k_raddr     = h_rd_q[VtxW-1:0];
    tri_ok      = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        h_we    = 1'b1;
        h_waddr = clr_q;
        h_wdata = '0;
        clr_d   = clr_q + HashW'(1);
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cur_d   = q_data_i;
          fcc_d   = fcc_eff;
          slot_d  = q_data_i.hash;
          h_re    = 1'b1;
          h_raddr = q_data_i.hash;
          res_d   = (fcc_eff >= FaceCntW'(FaceCorners)) ? RES_FACE_DROP : RES_NORMAL;
        end
      end
      ST_HCHK: begin
        if (h_rd_q[VtxW]) begin
          k_re  = 1'b1;
          vtx_d = h_rd_q[VtxW-1:0];
          new_d = 1'b0;
        end else if (vcnt_q >= VtxCntW'(VertexCapacity)) begin
          res_d = RES_OVERFLOW;
        end else begin
          h_we   = 1'b1;
          k_we   = 1'b1;
          vtx_d  = vcnt_q[VtxW-1:0];
          new_d  = 1'b1;
          vcnt_d = vcnt_q + VtxCntW'(1);
        end
      end
      ST_KCHK: begin
        if (k_rd_q != cur_q.key) begin
          slot_d  = slot_q + HashW'(1);
          h_re    = 1'b1;
          h_raddr = slot_q + HashW'(1);
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          unique case (res_q)
            RES_FACE_DROP: out_d.corner_dropped = 1'b1;
            RES_OVERFLOW: begin
              out_d.corner_dropped = 1'b1;
              out_d.table_overflow = 1'b1;
            end
            RES_NORMAL: begin
              tri_ok = (fcc_q >= FaceCntW'(2)) &&
                       (emit_sum < (EmitW+1)'(IndexCapacity));
              if (fcc_q == '0) first_d = vtx_q;
              if (tri_ok) emit_d = emit_sum[EmitW-1:0];
              out_d.vertex_index   = vtx_q;
              out_d.vertex_is_new  = new_q;
              out_d.triangle_valid = tri_ok;
              if (tri_ok) begin
                out_d.tri_first  = first_q;
                out_d.tri_second = prev_q;
                out_d.tri_third  = vtx_q;
              end
              prev_d = vtx_q;
              fcc_d  = fcc_q + FaceCntW'(1);
            end
            default: out_d.corner_dropped = 1'b1;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      vcnt_q      <= '0;
      emit_q      <= '0;
      first_q     <= '0;
      prev_q      <= '0;
      fcc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      vcnt_q      <= vcnt_d;
      emit_q      <= emit_d;
      first_q     <= first_d;
      prev_q      <= prev_d;
      fcc_q       <= fcc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    cur_q  <= cur_d;
    res_q  <= res_d;
    vtx_q  <= vtx_d;
    new_q  <= new_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (h_we) hash_mem[h_waddr] <= h_wdata;
    if (h_re) h_rd_q <= hash_mem[h_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (k_we) key_mem[vcnt_q[VtxW-1:0]] <= cur_q.key;
    if (k_re) k_rd_q <= key_mem[k_raddr];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
